>>> hw/rtl/mdlp_pkg.sv
`default_nettype none
package mdlp_pkg;

    localparam int unsigned TotalW = 61;
    localparam int unsigned RemW = 7;

    localparam logic [7:0] PadMarker = 8'h80;
    localparam logic [RemW-1:0] BlockBytes = 7'd64;
    localparam logic [RemW-1:0] LenBytes = 7'd8;
    localparam logic [RemW-1:0] MinPad = 7'd9;

    localparam logic ADDR_SECRET_LEN = 1'b0;
    localparam logic ADDR_LEN_LE = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } mdlp_push_t;

    typedef struct packed {
        logic can_take;
        logic can_last;
    } mdlp_pack_status_t;

    function automatic logic [63:0] byte_reverse(input logic [63:0] w);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = w[8*(7-i) +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mdlp_packer.sv
`default_nettype none
module mdlp_packer
    import mdlp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mdlp_push_t        push,
    output mdlp_pack_status_t      status,
    output logic                   word_valid,
    input  wire logic              word_ready,
    output logic [63:0]            out_word,
    output logic [3:0]             byte_count,
    output logic                   final_word
);

    logic [55:0] buf_reg;
    logic [2:0]  fill_reg;
    logic        valid_reg;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        final_reg;

    logic        can_emit;
    logic        emit;
    logic [63:0] wide;
    logic [2:0]  sh;
    logic [63:0] aligned;

    always_comb
    begin
        can_emit = !valid_reg || word_ready;
        emit = push.valid && ((fill_reg == 3'd7) || push.last);
        wide = {buf_reg, push.data};
        sh = 3'd7 - fill_reg;
        aligned = wide << {sh, 3'b000};
        status.can_take = can_emit || (fill_reg != 3'd7);
        status.can_last = can_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            fill_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (valid_reg && word_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (push.valid)
            begin
                if (emit)
                begin
                    valid_reg <= 1'b1;
                    buf_reg <= '0;
                    fill_reg <= '0;
                end
                else
                begin
                    buf_reg <= wide[55:0];
                    fill_reg <= fill_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid && emit)
        begin
            word_reg <= aligned;
            count_reg <= {1'b0, fill_reg} + 4'd1;
            final_reg <= push.last;
        end
    end

    assign word_valid = valid_reg;
    assign out_word = word_reg;
    assign byte_count = count_reg;
    assign final_word = final_reg;

endmodule
`default_nettype wire

>>> hw/rtl/md_length_padder.sv
// Channel   Handshake                Payload
// request   req_valid / req_ready    data_byte, has_byte, end_of_message
// result    word_valid / word_ready  out_word, byte_count, final_word
// config    APB psel/penable/pwrite  paddr, pwdata, prdata (secret_len @0, endianness @4)
// Message bytes enter one per cycle; a word leaves on every eighth byte.
// End of message starts the pad sequencer: one pad byte per cycle through the
// shared byte packer, 9 to 72 pad bytes, request channel held off meanwhile.
// A full result register with word_ready low stalls the packer and sequencer.
// Reset clears all control state; registers read back zero.
`default_nettype none
module md_length_padder
    import mdlp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_message,
    output logic             word_valid,
    input  wire logic        word_ready,
    output logic [63:0]      out_word,
    output logic [3:0]       byte_count,
    output logic             final_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PAD = 1'b1;

    logic              state_reg;
    logic [15:0]       secret_len_reg;
    logic              len_le_reg;
    logic              started_reg;
    logic [TotalW-1:0] total_reg;
    logic [RemW-1:0]   rem_reg;
    logic              first_reg;
    logic [63:0]       len_sr_reg;

    mdlp_push_t        push;
    mdlp_pack_status_t pk_status;

    logic              req_fire;
    logic              active;
    logic [TotalW-1:0] total_next;
    logic [63:0]       bits;
    logic [RemW-1:0]   plen;
    logic              pad_last;
    logic              pad_adv;
    logic              cfg_wr;

    always_comb
    begin
        req_ready = (state_reg == ST_IDLE) && pk_status.can_take;
        req_fire = req_valid && req_ready;
        active = has_byte || end_of_message;
        total_next = (started_reg ? total_reg : {{(TotalW-16){1'b0}}, secret_len_reg})
                     + {{(TotalW-1){1'b0}}, has_byte};
        bits = {total_next, 3'b000};
        plen = BlockBytes - {1'b0, total_next[5:0]};
        if (plen < MinPad)
        begin
            plen = plen + BlockBytes;
        end
        pad_last = (rem_reg == 7'd1);
        pad_adv = (state_reg == ST_PAD) &&
                  (pad_last ? pk_status.can_last : pk_status.can_take);

        push.valid = 1'b0;
        push.data = data_byte;
        push.last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                push.valid = req_fire && has_byte;
            end
            ST_PAD:
            begin
                push.valid = pad_adv;
                push.last = pad_last;
                if (first_reg)
                    push.data = PadMarker;
                else if (rem_reg <= LenBytes)
                    push.data = len_sr_reg[63:56];
                else
                    push.data = 8'h00;
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase

        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && pready;
        prdata = (paddr[2] == ADDR_LEN_LE) ? {31'b0, len_le_reg} : {16'b0, secret_len_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_len_reg <= '0;
            len_le_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ADDR_SECRET_LEN: secret_len_reg <= pwdata[15:0];
                ADDR_LEN_LE:     len_le_reg <= pwdata[0];
                default:         len_le_reg <= len_le_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            started_reg <= 1'b0;
            total_reg <= '0;
            rem_reg <= '0;
            first_reg <= 1'b0;
            len_sr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && active)
                    begin
                        if (end_of_message)
                        begin
                            started_reg <= 1'b0;
                            total_reg <= '0;
                            rem_reg <= plen;
                            first_reg <= 1'b1;
                            len_sr_reg <= len_le_reg ? byte_reverse(bits) : bits;
                            state_reg <= ST_PAD;
                        end
                        else
                        begin
                            started_reg <= 1'b1;
                            total_reg <= total_next;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (pad_adv)
                    begin
                        first_reg <= 1'b0;
                        if (!first_reg && (rem_reg <= LenBytes))
                        begin
                            len_sr_reg <= {len_sr_reg[55:0], 8'h00};
                        end
                        rem_reg <= rem_reg - 7'd1;
                        if (pad_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    mdlp_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .status     (pk_status),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .out_word   (out_word),
        .byte_count (byte_count),
        .final_word (final_word)
    );

endmodule
`default_nettype wire

>>> sim/md_length_padder_checker.sv
`timescale 1ns / 100ps
module md_length_padder_checker
    import mdlp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_message,
    input  wire logic        word_valid,
    input  wire logic        word_ready,
    input  wire logic [63:0] out_word,
    input  wire logic [3:0]  byte_count,
    input  wire logic        final_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               errors,
    output int               words_pending
);

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
    } padded_word_t;

    padded_word_t expected_words[$];
    padded_word_t head;

    logic [15:0] secret_len_q;
    logic        len_le_q;
    logic [60:0] total_bytes;
    logic [55:0] pack_buf;
    int unsigned pack_fill;
    bit          in_message;

    task automatic pack_byte(input logic [7:0] b);
        if (pack_fill == 7)
        begin
            expected_words.push_back('{{pack_buf, b}, 4'd8, 1'b0});
            pack_buf = '0;
            pack_fill = 0;
        end
        else
        begin
            pack_buf = {pack_buf[47:0], b};
            pack_fill++;
        end
    endtask

    task automatic pad_request(input logic [7:0] data, input logic has, input logic eom);
        int unsigned pad_len;
        logic [63:0] bit_len;
        padded_word_t tail;
        if (!has && !eom)
            return;
        if (!in_message)
        begin
            total_bytes = 61'(secret_len_q);
            in_message = 1'b1;
        end
        if (has)
        begin
            pack_byte(data);
            total_bytes = total_bytes + 61'd1;
        end
        if (eom)
        begin
            pad_len = 64 - int'(total_bytes[5:0]);
            if (pad_len < 9)
                pad_len += 64;
            bit_len = {total_bytes, 3'b000};
            pack_byte(PadMarker);
            repeat (pad_len - 9) pack_byte(8'h00);
            for (int i = 0; i < 8; i++)
                pack_byte(len_le_q ? bit_len[8*i +: 8] : bit_len[56-8*i +: 8]);
            if (pack_fill > 0)
            begin
                tail.word = 64'(pack_buf) << (8 * (8 - pack_fill));
                tail.count = 4'(pack_fill);
                tail.last = 1'b1;
                expected_words.push_back(tail);
            end
            else
            begin
                tail = expected_words.pop_back();
                tail.last = 1'b1;
                expected_words.push_back(tail);
            end
            total_bytes = '0;
            pack_buf = '0;
            pack_fill = 0;
            in_message = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            secret_len_q = '0;
            len_le_q = 1'b0;
            total_bytes = '0;
            pack_buf = '0;
            pack_fill = 0;
            in_message = 1'b0;
            errors = 0;
            words_pending = 0;
        end
        else
        begin
            if (word_valid && word_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: out_word %h byte_count %0d final_word %b",
                           out_word, byte_count, final_word);
                    errors++;
                end
                else
                begin
                    head = expected_words.pop_front();
                    if (out_word !== head.word)
                    begin
                        $error("out_word: expected %h, got %h", head.word, out_word);
                        errors++;
                    end
                    if (byte_count !== head.count)
                    begin
                        $error("byte_count: expected %0d, got %0d", head.count, byte_count);
                        errors++;
                    end
                    if (final_word !== head.last)
                    begin
                        $error("final_word: expected %b, got %b", head.last, final_word);
                        errors++;
                    end
                end
            end
            if (req_valid && req_ready)
                pad_request(data_byte, has_byte, end_of_message);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == ADDR_SECRET_LEN)
                    secret_len_q = pwdata[15:0];
                else if (paddr[2] == ADDR_LEN_LE)
                    len_le_q = pwdata[0];
            end
            words_pending = expected_words.size();
        end
    end

endmodule

>>> sim/tb_md_length_padder.sv
`timescale 1ns / 100ps
module tb_md_length_padder;
    import mdlp_pkg::*;

    localparam logic [2:0] SecretLenAddr = {ADDR_SECRET_LEN, 2'b00};
    localparam logic [2:0] LenLeAddr = {ADDR_LEN_LE, 2'b00};
    localparam int WatchdogLimit = 3000;
    localparam int LongHold = 400;
    localparam int DrainCycles = 100;
    localparam int RequestTarget = 260;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        end_of_message = 1'b0;
    logic        word_valid;
    logic        word_ready = 1'b0;
    logic [63:0] out_word;
    logic [3:0]  byte_count;
    logic        final_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int words_pending;
    int requests_sent = 0;
    int stall_cycles = 0;
    bit gaps_on = 1'b1;
    bit long_stall_go = 1'b0;

    always #4 clk = ~clk;

    md_length_padder dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
        .word_valid(word_valid), .word_ready(word_ready),
        .out_word(out_word), .byte_count(byte_count), .final_word(final_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    md_length_padder_checker padding_check (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
        .word_valid(word_valid), .word_ready(word_ready),
        .out_word(out_word), .byte_count(byte_count), .final_word(final_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .errors(errors), .words_pending(words_pending)
    );

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_stall_go)
            begin
                word_ready <= 1'b0;
                repeat (LongHold - 1) @(negedge clk);
                long_stall_go = 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < 6)
            begin
                word_ready <= 1'b0;
            end
            else
            begin
                word_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (word_valid && word_ready) || (psel && penable))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit)
            begin
                $display("md_length_padder regression: fail");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_request(input logic [7:0] data, input logic has, input logic eom);
        if (gaps_on && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        data_byte <= data;
        has_byte <= has;
        end_of_message <= eom;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (has || eom)
            requests_sent++;
    endtask

    // n_bytes message bytes; the end mark rides on the last byte or on its own request
    task automatic send_message(input int n_bytes, input bit end_on_byte);
        for (int k = 0; k < n_bytes; k++)
        begin
            if ($urandom_range(99) < 5)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, end_on_byte && k == n_bytes - 1);
        end
        if (!end_on_byte || n_bytes == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    initial
    begin
        int msg_idx;
        int len;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // secret 0, big-endian: empty message, idle request, byte extremes
        reg_write(SecretLenAddr, 32'd0);
        reg_write(LenLeAddr, 32'd0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h5A, 1'b1, 1'b1);
        send_request(8'h3C, 1'b1, 1'b0);
        send_request(8'hC3, 1'b0, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
        wait_idle();

        // exactly nine pad bytes fit, then one byte short of fitting
        reg_write(SecretLenAddr, 32'd55);
        reg_write(LenLeAddr, 32'd1);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h81, 1'b1, 1'b1);
        wait_idle();

        // largest secret, odd alignment
        reg_write(SecretLenAddr, 32'hFFFF_FFFF);
        reg_write(LenLeAddr, 32'hFFFF_FFFE);
        for (int k = 0; k < 7; k++)
            send_request((k % 2) ? 8'hFF : 8'h00, 1'b1, k == 6);
        wait_idle();

        reg_write(SecretLenAddr, 32'd63);
        reg_write(LenLeAddr, 32'd1);
        send_request(8'h00, 1'b0, 1'b1);
        send_message(8, 1'b1);
        wait_idle();

        msg_idx = 0;
        while (requests_sent < RequestTarget)
        begin
            gaps_on = !(msg_idx >= 10 && msg_idx < 18);
            if ($urandom_range(3) == 0)
            begin
                wait_idle();
                case ($urandom_range(3))
                    0: reg_write(SecretLenAddr, 32'd0);
                    1: reg_write(SecretLenAddr, 32'd65535);
                    2: reg_write(SecretLenAddr, $urandom_range(0, 130));
                    default: reg_write(SecretLenAddr, $urandom);
                endcase
                reg_write(LenLeAddr, $urandom);
            end
            if (msg_idx == 4)
            begin
                long_stall_go = 1'b1;
                len = 60;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 130)
                                               : $urandom_range(0, 20);
            end
            send_message(len, 1'($urandom_range(1)));
            msg_idx++;
        end

        wait_idle();
        if (errors == 0 && words_pending == 0)
            $display("md_length_padder regression: pass");
        else
            $display("md_length_padder regression: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mdlp_pkg.sv
hw/rtl/mdlp_packer.sv
hw/rtl/md_length_padder.sv
sim/md_length_padder_checker.sv
sim/tb_md_length_padder.sv
